FILE: rtl/camera_primary_ray_generation_defines.svh
// Assertion macros shared by the camera ray generator RTL.
`ifndef CAMERA_PRIMARY_RAY_GENERATION_DEFINES_SVH
`define CAMERA_PRIMARY_RAY_GENERATION_DEFINES_SVH
`ifndef SYNTHESIS
`define CRPG_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);
`define CRPG_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);
`else
`define CRPG_ASSERT_NOW(lbl, ant, cons, msg)
`define CRPG_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

FILE: rtl/crpg_pkg.sv
// Types, widths and register codes of the camera ray generator.
`default_nettype none
package crpg_pkg;
  localparam int COORD_BITS = 12;
  localparam int PROD_W = COORD_BITS + 17;
  localparam int TX_W = PROD_W + 16;
  localparam int M1_W = TX_W - 11;
  localparam int PH_W = M1_W + 16;
  localparam int MAG_W = 31;
  localparam int SUM_W = 64;
  localparam int LEN_W = 32;
  localparam int NUM_W = 46;
  localparam int QB = 15;
  localparam int DIR_W = 16;
  localparam int SQRT_STAGES = 32;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_INV_WIDTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_INV_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TAN_HALF_FOV = 3'd2;
  localparam logic [IDX_W-1:0] REG_CAM_POS_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_CAM_POS_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_CAM_POS_Z = 3'd5;

  localparam logic [15:0] INV_SIZE_RESET = 16'd256;
  localparam logic [15:0] TAN_RESET = 16'd4096;
  localparam logic [31:0] ASPECT_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } ray_t;
endpackage
`default_nettype wire

FILE: rtl/crpg_aspect_div.sv
// Radix-2 iterative divider for the aspect ratio inv_height/inv_width in Q16.16.
`default_nettype none
module crpg_aspect_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] inv_width,
  input  logic [15:0] inv_height,
  output logic        busy,
  output logic [31:0] aspect
);
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [4:0]  count;
  logic [16:0] rem_sh;
  logic        fits;

  // aspect doubles as the dividend shift register: dividend bits out, quotient bits in
  assign rem_sh = {rem, aspect[31]};
  assign fits = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      aspect <= crpg_pkg::ASPECT_RESET;
      rem <= '0;
      dsr <= crpg_pkg::INV_SIZE_RESET;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
      aspect <= {inv_height, 16'd0};
      rem <= '0;
      dsr <= inv_width;
    end else if (busy) begin
      rem <= fits ? 16'(rem_sh - {1'b0, dsr}) : rem_sh[15:0];
      aspect <= {aspect[30:0], fits};
      count <= count + 5'd1;
      if (count == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/crpg_unit_div.sv
// Pipelined restoring divider lane: one quotient bit per stage.
`default_nettype none
module crpg_unit_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [crpg_pkg::NUM_W-1:0]  num,
  input  logic [crpg_pkg::LEN_W-1:0]  den,
  output logic [crpg_pkg::QB-1:0]     quot
);
  logic [crpg_pkg::NUM_W-1:0] rem [crpg_pkg::QB+1];
  logic [crpg_pkg::LEN_W-1:0] dd  [crpg_pkg::QB+1];
  logic [crpg_pkg::QB-1:0]    q   [crpg_pkg::QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dd[0] <= den;
      q[0] <= '0;
    end
  end

  for (genvar j = 0; j < crpg_pkg::QB; j++) begin : g_stage
    localparam int BIT = crpg_pkg::QB - 1 - j;
    logic [crpg_pkg::NUM_W-1:0] dsh;
    assign dsh = crpg_pkg::NUM_W'(dd[j]) << BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        dd[j+1] <= dd[j];
        if (rem[j] >= dsh) begin
          rem[j+1] <= rem[j] - dsh;
          q[j+1] <= q[j] | (crpg_pkg::QB'(1) << BIT);
        end else begin
          rem[j+1] <= rem[j];
          q[j+1] <= q[j];
        end
      end
    end
  end

  assign quot = q[crpg_pkg::QB];
endmodule
`default_nettype wire

FILE: rtl/camera_primary_ray_generation.sv
// Pinhole camera primary ray generator: pixel in, normalized ray out.
// Pipeline: 8 front stages, 32 square-root stages, 16 divider stages and the
// output register. Throughput: one pixel per cycle while the skid register is
// empty; after a write to inv_width or inv_height the input waits while the
// aspect divider runs one bit per cycle.
// Reset (rst, synchronous): registers return to their reset values, pipe empties.
`default_nettype none
`include "camera_primary_ray_generation_defines.svh"
module camera_primary_ray_generation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_ready,
  input  crpg_pkg::pixel_t             pixel,
  output logic                         ray_valid,
  input  logic                         ray_ready,
  output crpg_pkg::ray_t               ray,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [crpg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [31:0]                  cfg_data
);
  localparam int PW = crpg_pkg::PROD_W;
  localparam int NS = crpg_pkg::SQRT_STAGES;
  localparam logic [PW-1:0] ONE_Q16 = PW'(65536);
  localparam logic [crpg_pkg::MAG_W-1:0] MAG_MAX = '1;

  // configuration registers
  logic [15:0] inv_width, inv_height, tan_half_fov;
  logic [31:0] cam_pos_x, cam_pos_y, cam_pos_z;
  logic        aspect_go;
  logic        aspect_busy;
  logic [31:0] aspect;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_width <= crpg_pkg::INV_SIZE_RESET;
      inv_height <= crpg_pkg::INV_SIZE_RESET;
      tan_half_fov <= crpg_pkg::TAN_RESET;
      cam_pos_x <= '0;
      cam_pos_y <= '0;
      cam_pos_z <= '0;
      aspect_go <= 1'b0;
    end else begin
      aspect_go <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          crpg_pkg::REG_INV_WIDTH: begin
            inv_width <= cfg_data[15:0];
            aspect_go <= 1'b1;
          end
          crpg_pkg::REG_INV_HEIGHT: begin
            inv_height <= cfg_data[15:0];
            aspect_go <= 1'b1;
          end
          crpg_pkg::REG_TAN_HALF_FOV: tan_half_fov <= cfg_data[15:0];
          crpg_pkg::REG_CAM_POS_X: cam_pos_x <= cfg_data;
          crpg_pkg::REG_CAM_POS_Y: cam_pos_y <= cfg_data;
          crpg_pkg::REG_CAM_POS_Z: cam_pos_z <= cfg_data;
          default: ;  // drop writes to unknown indexes
        endcase
      end
    end
  end

  // recompute the aspect ratio after either inverse size changes
  crpg_aspect_div u_aspect (
    .clk        (clk),
    .rst        (rst),
    .start      (aspect_go),
    .inv_width  (inv_width),
    .inv_height (inv_height),
    .busy       (aspect_busy),
    .aspect     (aspect)
  );

  // whole pipe advances unless the skid register holds a result
  logic   en;
  logic   skid_valid;
  crpg_pkg::ray_t skid;

  assign en = !skid_valid;
  assign pixel_ready = en && !aspect_go && !aspect_busy;

  // front stages: screen coordinates and their squares
  logic                         v1, v2, v3, v4, v5, v6, v7;
  logic [PW-1:0]                p1x, p1y;
  logic [PW-1:0]                m2x, m2y;
  logic                         s2x, s2y, s3x, s3y, s4x, s4y, s5x, s5y, s6x, s6y, s7x, s7y;
  logic [crpg_pkg::TX_W-1:0]    t3x, t3y;
  logic [crpg_pkg::M1_W-1:0]    m4x;
  logic [crpg_pkg::MAG_W-1:0]   m4y, m5y, m6x, m6y, m7x, m7y;
  logic [crpg_pkg::PH_W-1:0]    ph5, pl5;
  logic [61:0]                  q7x, q7y;

  logic [crpg_pkg::TX_W:0]      rnd_x, rnd_y;
  logic [crpg_pkg::M1_W-1:0]    y_pre;
  logic [crpg_pkg::PH_W:0]      x_pre;

  assign rnd_x = t3x + (crpg_pkg::TX_W+1)'(2048);
  assign rnd_y = t3y + (crpg_pkg::TX_W+1)'(2048);
  assign y_pre = rnd_y[crpg_pkg::TX_W:12];
  assign x_pre = (crpg_pkg::PH_W+1)'(ph5)
               + (crpg_pkg::PH_W+1)'((pl5 + crpg_pkg::PH_W'(32768)) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else if (en) begin
      v1 <= pixel_valid && pixel_ready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1x <= PW'({pixel.pixel_x, 1'b1}) * PW'(inv_width);
      p1y <= PW'({pixel.pixel_y, 1'b1}) * PW'(inv_height);
      // nx = p1x - 1.0, ny = 1.0 - p1y, kept as sign and magnitude
      s2x <= p1x < ONE_Q16;
      m2x <= (p1x < ONE_Q16) ? ONE_Q16 - p1x : p1x - ONE_Q16;
      s2y <= p1y > ONE_Q16;
      m2y <= (p1y > ONE_Q16) ? p1y - ONE_Q16 : ONE_Q16 - p1y;
      s3x <= s2x;
      s3y <= s2y;
      t3x <= crpg_pkg::TX_W'(m2x) * crpg_pkg::TX_W'(tan_half_fov);
      t3y <= crpg_pkg::TX_W'(m2y) * crpg_pkg::TX_W'(tan_half_fov);
      s4x <= s3x;
      s4y <= s3y;
      m4x <= rnd_x[crpg_pkg::TX_W:12];
      m4y <= (y_pre > crpg_pkg::M1_W'(MAG_MAX)) ? MAG_MAX : crpg_pkg::MAG_W'(y_pre);
      // aspect applied as integer and fraction halves, fraction rounded
      s5x <= s4x;
      s5y <= s4y;
      m5y <= m4y;
      ph5 <= crpg_pkg::PH_W'(m4x) * crpg_pkg::PH_W'(aspect[31:16]);
      pl5 <= crpg_pkg::PH_W'(m4x) * crpg_pkg::PH_W'(aspect[15:0]);
      s6x <= s5x;
      s6y <= s5y;
      m6y <= m5y;
      m6x <= (x_pre > (crpg_pkg::PH_W+1)'(MAG_MAX)) ? MAG_MAX : crpg_pkg::MAG_W'(x_pre);
      s7x <= s6x;
      s7y <= s6y;
      m7x <= m6x;
      m7y <= m6y;
      q7x <= 62'(m6x) * 62'(m6x);
      q7y <= 62'(m6y) * 62'(m6y);
    end
  end

  // square root of x'^2 + y'^2 + 1.0^2, one root bit per stage
  logic                          sqv [NS+1];
  logic [crpg_pkg::SUM_W-1:0]    sqs [NS+1];
  logic [crpg_pkg::SUM_W-1:0]    sqr [NS+1];
  logic [crpg_pkg::MAG_W-1:0]    sqmx [NS+1];
  logic [crpg_pkg::MAG_W-1:0]    sqmy [NS+1];
  logic                          sqsx [NS+1];
  logic                          sqsy [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (en) begin
      sqv[0] <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqs[0] <= 64'(q7x) + 64'(q7y) + (64'd1 << 32);
      sqr[0] <= '0;
      sqmx[0] <= m7x;
      sqmy[0] <= m7y;
      sqsx[0] <= s7x;
      sqsy[0] <= s7y;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [crpg_pkg::SUM_W-1:0] BIT = 64'd1 << (2 * (NS - 1 - k));
    logic [crpg_pkg::SUM_W-1:0] trial;
    assign trial = sqr[k] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else if (en) begin
        sqv[k+1] <= sqv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (sqs[k] >= trial) begin
          sqs[k+1] <= sqs[k] - trial;
          sqr[k+1] <= (sqr[k] >> 1) + BIT;
        end else begin
          sqs[k+1] <= sqs[k];
          sqr[k+1] <= sqr[k] >> 1;
        end
        sqmx[k+1] <= sqmx[k];
        sqmy[k+1] <= sqmy[k];
        sqsx[k+1] <= sqsx[k];
        sqsy[k+1] <= sqsy[k];
      end
    end
  end

  // rounded division of each component by the length
  logic [crpg_pkg::LEN_W-1:0] len;
  logic [crpg_pkg::NUM_W-1:0] num_x, num_y, num_z;
  logic [crpg_pkg::QB-1:0]    qx, qy, qz;
  logic                       dv [crpg_pkg::QB+1];
  logic                       dsx [crpg_pkg::QB+1];
  logic                       dsy [crpg_pkg::QB+1];

  assign len = sqr[NS][crpg_pkg::LEN_W-1:0];
  assign num_x = {1'b0, sqmx[NS], 14'd0} + crpg_pkg::NUM_W'(len >> 1);
  assign num_y = {1'b0, sqmy[NS], 14'd0} + crpg_pkg::NUM_W'(len >> 1);
  assign num_z = (crpg_pkg::NUM_W'(1) << 30) + crpg_pkg::NUM_W'(len >> 1);

  crpg_unit_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(len), .quot(qx));
  crpg_unit_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(len), .quot(qy));
  crpg_unit_div u_div_z (.clk(clk), .en(en), .num(num_z), .den(len), .quot(qz));

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sqv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsx[0] <= sqsx[NS];
      dsy[0] <= sqsy[NS];
    end
  end

  for (genvar j = 0; j < crpg_pkg::QB; j++) begin : g_dctl
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dsx[j+1] <= dsx[j];
        dsy[j+1] <= dsy[j];
      end
    end
  end

  // assemble the result: apply signs, attach the camera position
  crpg_pkg::ray_t res;
  logic [crpg_pkg::DIR_W-1:0] ux, uy, uz;

  assign ux = {1'b0, qx};
  assign uy = {1'b0, qy};
  assign uz = {1'b0, qz};

  always_comb begin
    res.dir_x = dsx[crpg_pkg::QB] ? -ux : ux;
    res.dir_y = dsy[crpg_pkg::QB] ? -uy : uy;
    res.dir_z = -uz;
    res.origin_x = cam_pos_x;
    res.origin_y = cam_pos_y;
    res.origin_z = cam_pos_z;
  end

  // output register with a one-item skid: the pipe keeps moving for one
  // more item while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (!ray_valid || ray_ready) begin
        ray_valid <= dv[crpg_pkg::QB];
        ray <= res;
      end else if (dv[crpg_pkg::QB]) begin
        skid_valid <= 1'b1;
        skid <= res;
      end
    end else if (ray_ready) begin
      ray <= skid;
      skid_valid <= 1'b0;
    end
  end

  `CRPG_ASSERT_NOW(a_skid_has_out, skid_valid, ray_valid, "skid holds item with empty output")
  `CRPG_ASSERT_NEXT(a_skid_holds, skid_valid && !ray_ready, skid_valid, "skid item lost")
  `CRPG_ASSERT_NOW(a_no_take_busy, aspect_busy || aspect_go, !pixel_ready, "pixel taken during aspect update")
  `CRPG_ASSERT_NOW(a_dir_z_nonpos, ray_valid, ray.dir_z[15] || ray.dir_z == 16'sd0, "dir_z positive")
endmodule
`default_nettype wire

FILE: dv/camera_primary_ray_generation_tb.sv
// Self-checking testbench for the pinhole camera primary ray generator.
`default_nettype none
module camera_primary_ray_generation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 57;
  localparam logic [crpg_pkg::IDX_W-1:0] REG_UNKNOWN = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  crpg_pkg::pixel_t pixel = '0;
  logic ray_valid;
  logic ray_ready = 1'b0;
  crpg_pkg::ray_t ray;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [crpg_pkg::IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  camera_primary_ray_generation dut (
    .clk, .rst, .pixel_valid, .pixel_ready, .pixel, .ray_valid, .ray_ready, .ray,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  // Camera settings as the predictor sees them.
  logic [15:0] cam_inv_w, cam_inv_h, cam_tan;
  logic [31:0] cam_px, cam_py, cam_pz;

  crpg_pkg::pixel_t pixel_queue[$];
  crpg_pkg::ray_t ray_expected[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_part(logic neg, logic [63:0] m, logic [63:0] len);
    logic [63:0] q;
    q = (m * 64'd16384 + len / 2) / len;
    return neg ? 16'(-q) : 16'(q);
  endfunction

  // Trace the ray through one pixel center under the current settings.
  function automatic crpg_pkg::ray_t trace_pixel(crpg_pkg::pixel_t p);
    crpg_pkg::ray_t r;
    logic [63:0] aspect, mx, my, m1, len;
    longint nx, ny;
    if (cam_inv_w == 0) aspect = 64'hFFFF_FFFF;
    else aspect = (64'(cam_inv_h) << 16) / cam_inv_w;
    nx = longint'((2 * 64'(p.pixel_x) + 1) * cam_inv_w) - 65536;
    ny = 65536 - longint'((2 * 64'(p.pixel_y) + 1) * cam_inv_h);
    mx = nx < 0 ? 64'(-nx) : 64'(nx);
    m1 = (mx * cam_tan + 2048) >> 12;
    mx = m1 * (aspect >> 16) + ((m1 * (aspect & 64'hFFFF) + 32768) >> 16);
    if (mx > 64'h7FFF_FFFF) mx = 64'h7FFF_FFFF;
    my = ny < 0 ? 64'(-ny) : 64'(ny);
    my = (my * cam_tan + 2048) >> 12;
    if (my > 64'h7FFF_FFFF) my = 64'h7FFF_FFFF;
    len = root64(mx * mx + my * my + (64'd1 << 32));
    r.dir_x = unit_part(nx < 0, mx, len);
    r.dir_y = unit_part(ny < 0, my, len);
    r.dir_z = unit_part(1'b1, 64'd65536, len);
    r.origin_x = cam_px;
    r.origin_y = cam_py;
    r.origin_z = cam_pz;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // Driver: present the head of the pixel queue, hold until accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && pixel_ready) begin
        ray_expected.push_back(trace_pixel(pixel));
        void'(pixel_queue.pop_front());
      end
      if (!pixel_valid || pixel_ready) begin
        if ((pixel_valid && pixel_ready ? pixel_queue.size() > 0 : pixel_queue.size() > 0)
            && $urandom_range(99) >= send_idle_pct) begin
          pixel_valid <= 1'b1;
          pixel <= pixel_valid && pixel_ready ? pixel_queue[0] : pixel_queue[0];
        end else begin
          pixel_valid <= 1'b0;
        end
      end
      ray_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Monitor: compare each accepted ray with the oldest prediction.
  always @(posedge clk) begin
    crpg_pkg::ray_t want;
    if (!rst && ray_valid && ray_ready) begin
      if (ray_expected.size() == 0) begin
        report_mismatch("unexpected ray", 32'(ray.dir_x), 32'h0);
      end else begin
        want = ray_expected.pop_front();
        if (ray.dir_x !== want.dir_x) report_mismatch("dir_x", 32'(ray.dir_x), 32'(want.dir_x));
        if (ray.dir_y !== want.dir_y) report_mismatch("dir_y", 32'(ray.dir_y), 32'(want.dir_y));
        if (ray.dir_z !== want.dir_z) report_mismatch("dir_z", 32'(ray.dir_z), 32'(want.dir_z));
        if (ray.origin_x !== want.origin_x) report_mismatch("origin_x", ray.origin_x, want.origin_x);
        if (ray.origin_y !== want.origin_y) report_mismatch("origin_y", ray.origin_y, want.origin_y);
        if (ray.origin_z !== want.origin_z) report_mismatch("origin_z", ray.origin_z, want.origin_z);
      end
    end
  end

  // Write one register; the predictor follows at the accepting edge.
  // Valid stays high for the next write; the caller drops it at the end.
  task automatic write_reg(logic [crpg_pkg::IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      crpg_pkg::REG_INV_WIDTH: cam_inv_w = data[15:0];
      crpg_pkg::REG_INV_HEIGHT: cam_inv_h = data[15:0];
      crpg_pkg::REG_TAN_HALF_FOV: cam_tan = data[15:0];
      crpg_pkg::REG_CAM_POS_X: cam_px = data;
      crpg_pkg::REG_CAM_POS_Y: cam_py = data;
      crpg_pkg::REG_CAM_POS_Z: cam_pz = data;
      default: ;
    endcase
  endtask

  // Wait until every queued pixel is in and every ray is out.
  task automatic drain();
    while (pixel_queue.size() > 0 || pixel_valid || ray_expected.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic crpg_pkg::pixel_t rand_pixel();
    crpg_pkg::pixel_t p;
    p.pixel_x = crpg_pkg::COORD_BITS'($urandom);
    p.pixel_y = crpg_pkg::COORD_BITS'($urandom);
    return p;
  endfunction

  task automatic load_settings(int mode);
    case (mode)
      0: begin
        write_reg(crpg_pkg::REG_INV_WIDTH, 32'd16);
        write_reg(crpg_pkg::REG_INV_HEIGHT, 32'd16);
      end
      1: begin
        write_reg(crpg_pkg::REG_INV_WIDTH, 32'd65535);
        write_reg(crpg_pkg::REG_INV_HEIGHT, 32'd65535);
        write_reg(crpg_pkg::REG_TAN_HALF_FOV, 32'd65535);
      end
      2: begin
        write_reg(crpg_pkg::REG_INV_WIDTH, 32'd1);
        write_reg(crpg_pkg::REG_INV_HEIGHT, 32'd65535);
        write_reg(crpg_pkg::REG_TAN_HALF_FOV, 32'd0);
      end
      3: begin
        // zero width saturates the aspect ratio
        write_reg(crpg_pkg::REG_INV_WIDTH, 32'd0);
        write_reg(crpg_pkg::REG_TAN_HALF_FOV, 32'd4096);
      end
      default: begin
        write_reg(crpg_pkg::REG_INV_WIDTH, $urandom_range(65535, 1));
        write_reg(crpg_pkg::REG_INV_HEIGHT, $urandom_range(65535, 1));
        write_reg(crpg_pkg::REG_TAN_HALF_FOV, $urandom_range(65535));
      end
    endcase
    write_reg(crpg_pkg::REG_CAM_POS_X, $urandom);
    write_reg(crpg_pkg::REG_CAM_POS_Y, $urandom);
    write_reg(crpg_pkg::REG_CAM_POS_Z, $urandom);
    // unknown index is ignored
    write_reg(REG_UNKNOWN, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    crpg_pkg::pixel_t p;
    int waited;
    cam_inv_w = crpg_pkg::INV_SIZE_RESET;
    cam_inv_h = crpg_pkg::INV_SIZE_RESET;
    cam_tan = crpg_pkg::TAN_RESET;
    cam_px = '0;
    cam_py = '0;
    cam_pz = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners and centers at reset settings.
    for (int i = 0; i < 16; i++) begin
      p.pixel_x = (i & 1) ? '1 : ((i & 4) ? 12'd128 : 12'd0);
      p.pixel_y = (i & 2) ? '1 : ((i & 8) ? 12'd127 : 12'd0);
      pixel_queue.push_back(p);
    end
    drain();

    // Random: settings sweep with each idling phase.
    for (int ph = 0; ph < 24; ph++) begin
      load_settings(ph % 8);
      case ((ph / 2) % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int i = 0; i < 76; i++) pixel_queue.push_back(rand_pixel());
      drain();
    end

    waited = 0;
    while (ray_expected.size() > 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && ray_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
